// ----- src/rdnd_pkg.sv -----
// Shared constants for the ray distance to window depth pipeline.
package rdnd_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_PLANE_X      = 3'd2;
  localparam logic [2:0] REG_PLANE_Y      = 3'd3;
  localparam logic [2:0] REG_EYE_LEN_SQ   = 3'd4;
  localparam logic [2:0] REG_COEFF_A      = 3'd5;
  localparam logic [2:0] REG_COEFF_B      = 3'd6;

  // Stage counts of the pipeline sections
  localparam int AXIS_LAT = 24;  // clamp, 20 quotient bits, scale, round, square
  localparam int SQRT_LAT = 24;  // one root bit per stage
  localparam int QUO_LAT  = 40;  // one quotient bit per stage
  localparam int D_LAT    = AXIS_LAT + 1 + SQRT_LAT;
  localparam int PIPE_LAT = D_LAT + 1 + QUO_LAT;

endpackage

// ----- src/rdnd_delay.sv -----
// Shift line that carries side data and valid bits alongside the datapath.
module rdnd_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] din_i,
  output logic [W-1:0] dout_o
);

  logic [W-1:0] line_q [N];

  // Advance all taps together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) line_q[k] <= '0;
    end else if (en_i) begin
      line_q[0] <= din_i;
      for (int k = 1; k < N; k++) line_q[k] <= line_q[k-1];
    end
  end

  assign dout_o = line_q[N-1];

endmodule

// ----- src/rdnd_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module rdnd_div #(
  parameter int DW = 14,
  parameter int QW = 20
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] rem_i,   // upper part of dividend, below den_i
  input  logic [QW-1:0] low_i,   // dividend bits brought down, msb first
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_s [QW+1];
  logic [QW-1:0] low_s [QW+1];
  logic [DW-1:0] den_s [QW+1];
  logic [QW-1:0] quo_s [QW+1];

  assign rem_s[0] = rem_i;
  assign low_s[0] = low_i;
  assign den_s[0] = den_i;
  assign quo_s[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0] rem2;
    logic        ge;

    // Bring down one bit and try the subtraction
    assign rem2 = {rem_s[k], low_s[k][QW-1]};
    assign ge   = rem2 >= {1'b0, den_s[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[k+1] <= ge ? DW'(rem2 - {1'b0, den_s[k]}) : rem2[DW-1:0];
        low_s[k+1] <= low_s[k] << 1;
        den_s[k+1] <= den_s[k];
        quo_s[k+1] <= {quo_s[k][QW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_s[QW];

endmodule

// ----- src/rdnd_sqrt.sv -----
// Pipelined integer square root of a 48-bit value, one root bit per stage.
module rdnd_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [47:0] rad_i,
  output logic [23:0] root_o
);

  logic [47:0] rad_s  [25];
  logic [25:0] rem_s  [25];
  logic [23:0] root_s [25];

  assign rad_s[0]  = rad_i;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;

  for (genvar k = 0; k < 24; k++) begin : g_stage
    logic [27:0] rem2;
    logic [27:0] trial;
    logic        ge;

    // Bring down two bits and test the next root bit
    assign rem2  = {rem_s[k], rad_s[k][47:46]};
    assign trial = {2'b00, root_s[k], 2'b01};
    assign ge    = rem2 >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_s[k+1]  <= rad_s[k] << 2;
        rem_s[k+1]  <= ge ? 26'(rem2 - trial) : rem2[25:0];
        root_s[k+1] <= {root_s[k][22:0], ge};
      end
    end
  end

  assign root_o = root_s[24];

endmodule

// ----- src/rdnd_axis.sv -----
// Squared screen offset (u*s)^2 in Q.40 for one image axis.
module rdnd_axis #(
  parameter int MAX_DIM = 4096
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [12:0] dim_i,
  input  logic [23:0] size_i,
  input  logic [11:0] idx_i,
  output logic [47:0] sq_o
);

  localparam logic [14:0] MaxDim = 15'(MAX_DIM);

  logic [12:0] dim_c, w1_c, idx_c;
  logic [13:0] twice_c, w1_e;
  logic [12:0] mag_c;
  logic [12:0] mag_q, w1_q;
  logic [19:0] uq;
  logic [43:0] p_q;
  logic [44:0] p_rnd;
  logic [23:0] p20_q;
  logic [47:0] sq_q;

  // Clamp size and index, take distance from the image center
  always_comb begin
    dim_c = dim_i;
    if (dim_i < 13'd2) dim_c = 13'd2;
    else if ({2'b00, dim_i} > MaxDim) dim_c = 13'(MaxDim);
    w1_c    = dim_c - 13'd1;
    idx_c   = ({1'b0, idx_i} > w1_c) ? w1_c : {1'b0, idx_i};
    twice_c = {idx_c, 1'b0};
    w1_e    = {1'b0, w1_c};
    mag_c   = (twice_c >= w1_e) ? 13'(twice_c - w1_e) : 13'(w1_e - twice_c);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_c;
      w1_q  <= w1_c;
    end
  end

  // |u| in Q.20 rounded half up: ((mag << 20) + w1) / (2 * w1)
  rdnd_div #(.DW(14), .QW(20)) u_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .rem_i ({1'b0, mag_q}),
    .low_i ({7'd0, w1_q}),
    .den_i ({w1_q, 1'b0}),
    .quo_o (uq)
  );

  // Scale, round to Q.20, square
  assign p_rnd = {1'b0, p_q} + 45'd524288;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q   <= uq * size_i;
      p20_q <= p_rnd[43:20];
      sq_q  <= p20_q * p20_q;
    end
  end

  assign sq_o = sq_q;

endmodule

// ----- src/ray_distance_to_ndc_depth_core.sv -----
// Top level: ray hit distance to 24-bit perspective window depth.
//
//  channel   direction  handshake                payload
//  in        input      in_valid_i / in_stall_o  ray_distance, is_miss, column, row
//  out       output     out_valid_o / out_stall_i  window_depth
//  cfg       input      cfg_we_i                 cfg_index_i, cfg_data_i
//
// One request per cycle while in_stall_o is low; a stall holds the whole pipe.
// Most of the pipeline depth lies in the divide and root sections, which resolve
// 20 bits for the screen offset, 24 for the square root and 40 for the final quotient.
// All stages advance together when the output register is empty or taken.
// Reset clears the valid line and loads register defaults; no clearing pass.
module ray_distance_to_ndc_depth_core #(
  parameter int MAX_DIM = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] ray_distance_i,
  input  logic        is_miss_i,
  input  logic [11:0] column_i,
  input  logic [11:0] row_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] window_depth_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [12:0]        image_width_q, image_height_q;
  logic [23:0]        plane_size_x_q, plane_size_y_q, eye_len_sq_q;
  logic signed [31:0] coeff_a_q, coeff_b_q;

  logic        adv;
  logic        kill_in;
  logic [1:0]  ctl_end;
  logic [31:0] d_dly;
  logic [47:0] sqx, sqy;
  logic [47:0] s_q;
  logic [23:0] root;
  logic [31:0] bmag;
  logic [55:0] num_q, den_q;
  logic        ovf, ovf_dly;
  logic [39:0] quo;
  logic [41:0] qmag;
  logic signed [43:0] t_s, a_s, v_s;
  logic [23:0] depth_d;
  logic        out_valid_q;
  logic [23:0] depth_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= 13'd1024;
      image_height_q <= 13'd768;
      plane_size_x_q <= 24'h100000;
      plane_size_y_q <= 24'h100000;
      eye_len_sq_q   <= 24'h100000;
      coeff_a_q      <= -32'sd65667;
      coeff_b_q      <= -32'sd13120;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rdnd_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[12:0];
        rdnd_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[12:0];
        rdnd_pkg::REG_PLANE_X:      plane_size_x_q <= cfg_data_i[23:0];
        rdnd_pkg::REG_PLANE_Y:      plane_size_y_q <= cfg_data_i[23:0];
        rdnd_pkg::REG_EYE_LEN_SQ:   eye_len_sq_q   <= cfg_data_i[23:0];
        rdnd_pkg::REG_COEFF_A:      coeff_a_q      <= $signed(cfg_data_i);
        rdnd_pkg::REG_COEFF_B:      coeff_b_q      <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Advance the whole pipe when the output register is free
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // Miss, zero distance or zero eye length force depth to one
  assign kill_in = is_miss_i || (ray_distance_i == 32'd0) || (eye_len_sq_q == 24'd0);

  rdnd_delay #(.W(2), .N(rdnd_pkg::PIPE_LAT)) u_ctl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .din_i  ({in_valid_i, kill_in}),
    .dout_o (ctl_end)
  );

  rdnd_delay #(.W(32), .N(rdnd_pkg::D_LAT)) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .din_i  (ray_distance_i),
    .dout_o (d_dly)
  );

  // Screen offset terms
  rdnd_axis #(.MAX_DIM(MAX_DIM)) u_axis_x (
    .clk_i  (clk_i),
    .en_i   (adv),
    .dim_i  (image_width_q),
    .size_i (plane_size_x_q),
    .idx_i  (column_i),
    .sq_o   (sqx)
  );

  rdnd_axis #(.MAX_DIM(MAX_DIM)) u_axis_y (
    .clk_i  (clk_i),
    .en_i   (adv),
    .dim_i  (image_height_q),
    .size_i (plane_size_y_q),
    .idx_i  (row_i),
    .sq_o   (sqy)
  );

  // Sum of squares, then its root
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q <= {eye_len_sq_q, 20'd0} + sqx + sqy;
    end
  end

  rdnd_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (s_q),
    .root_o (root)
  );

  // Numerator |B|*r and denominator d*c2
  assign bmag = coeff_b_q[31] ? 32'(-coeff_b_q) : 32'(coeff_b_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q <= bmag * root;
      den_q <= d_dly * eye_len_sq_q;
    end
  end

  // Cap when the integer part of the quotient reaches 2^17
  assign ovf = {17'd0, num_q} >= {den_q, 17'd0};

  rdnd_delay #(.W(1), .N(rdnd_pkg::QUO_LAT)) u_ovf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .din_i  (ovf),
    .dout_o (ovf_dly)
  );

  rdnd_div #(.DW(56), .QW(rdnd_pkg::QUO_LAT)) u_quo (
    .clk_i (clk_i),
    .en_i  (adv),
    .rem_i ({17'd0, num_q[55:17]}),
    .low_i ({num_q[16:0], 23'd0}),
    .den_i (den_q),
    .quo_o (quo)
  );

  // Combine with A, saturate to the unit range; killed requests give depth one
  always_comb begin
    qmag    = ovf_dly ? (42'd1 << 41) : {2'b00, quo};
    t_s     = coeff_b_q[31] ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag});
    a_s     = 44'(coeff_a_q) <<< 7;
    v_s     = 44'sd8388608 - a_s + t_s;
    if (ctl_end[0]) depth_d = '1;
    else if (v_s[43]) depth_d = '0;
    else if (v_s > 44'sd16777215) depth_d = '1;
    else depth_d = v_s[23:0];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= ctl_end[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      depth_q <= depth_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign window_depth_o = depth_q;

  a_kill_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && ctl_end[1] && ctl_end[0]) |=> (window_depth_o == 24'hFFFFFF))
    else $error("killed request did not give depth one");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && ctl_end[1]) |=> out_valid_o)
    else $error("request at pipe end was lost");

  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !ctl_end[1]) |=> !out_valid_o)
    else $error("output valid without a request at pipe end");

endmodule
